FILE: hw/rtl/ax25_pkg.sv
// Package for the AX.25 UI frame to monitor text decoder.
// Holds shared types and constants; no dependencies.
package ax25_pkg;
   localparam int unsigned PATH_STORE_DEF = 64;
   localparam logic [15:0] CAP_RESET = 16'd256;
   localparam int unsigned ADDR_TEXT = 9;
   localparam logic [7:0] CTRL_UI = 8'h03;

   // header source select
   typedef enum logic [2:0] {
      SEL_SRC, SEL_GT, SEL_DST, SEL_PATH, SEL_COLON
   } hsel_type;

   typedef struct packed {
      logic       clear;       // new frame
      logic       addr_wr;     // decode address byte
      logic [1:0] addr_field;  // 0 dest 1 src 2 hop
      logic [2:0] addr_idx;
      logic       hop_clear;
      logic       copy_start;  // start copying hop into path
      logic       hdr_start;   // reset header pointer
      logic       hdr_step;    // advance header pointer
   } cmd_type;

   typedef struct packed {
      logic       copy_busy;
      logic       hop_fits;
      logic [6:0] hdr_char;
      logic       hdr_end;     // pointer at end of header
      logic [8:0] hdr_len;
   } sts_type;
endpackage

FILE: hw/rtl/ax25_ui_frame_to_text_top.sv
// Top level of the AX.25 UI frame to monitor text decoder.
// Depends on ax25_pkg, ax25_ctrl and ax25_datapath.
//
// Frame bytes enter on req_ (valid/stall), one request per byte, with
// req_frame_last on the final byte. Monitor text "SRC>DST,PATH:info" leaves
// on rsp_ one character per cycle, rsp_end_of_text on the final character.
// csr_ writes the text capacity (ready always high); write only when idle.
// Address and info bytes stall only on a stalled output. A digipeater field
// stalls requests while the hop text is copied into the path RAM.
// The control and PID bytes start header bursts of one character per cycle,
// up to 64 each, during which req_stall is held high. A stalled receiver
// holds the output register and, through it, the request side.
// Synchronous reset returns to awaiting a destination address and restores
// the capacity to 256.
module ax25_ui_frame_to_text_top #(
   parameter int unsigned PATH_STORE = ax25_pkg::PATH_STORE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_text_capacity,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_text_char,
   output logic        rsp_end_of_text
);
   import ax25_pkg::*;
   cmd_type cmd;
   sts_type sts;

   ax25_ctrl u_ctrl (
      .clock, .reset, .csr_valid, .csr_ready, .csr_text_capacity,
      .req_valid, .req_stall, .req_frame_byte, .req_frame_last,
      .rsp_valid, .rsp_stall, .rsp_text_char, .rsp_end_of_text,
      .cmd, .sts
   );

   ax25_datapath #(.PATH_STORE(PATH_STORE)) u_dp (
      .clock, .reset, .byte_in(req_frame_byte), .cmd, .sts
   );
endmodule

FILE: hw/rtl/ax25_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
module ax25_ram #(
   parameter int unsigned WIDTH = 7,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: hw/rtl/ax25_datapath.sv
// Datapath: address decode buffers, path RAM, header character sequencer.
// Depends on ax25_pkg and ax25_ram.
module ax25_datapath #(
   parameter int unsigned PATH_STORE = ax25_pkg::PATH_STORE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        byte_in,
   input  ax25_pkg::cmd_type cmd,
   output ax25_pkg::sts_type sts
);
   import ax25_pkg::*;
   localparam int unsigned AW = $clog2(PATH_STORE);
   localparam int unsigned PLW = $clog2(PATH_STORE + 1);

   logic [6:0] dst_ff [ADDR_TEXT];
   logic [6:0] src_ff [ADDR_TEXT];
   logic [6:0] hop_ff [ADDR_TEXT];
   logic [3:0] dlen_ff, slen_ff, hlen_ff;
   logic [PLW-1:0] plen_ff;
   logic [3:0] ck_ff;
   logic copy_ff;
   hsel_type sel_ff;
   logic [PLW-1:0] hp_ff;   // index within current segment
   logic [8:0] hcnt_ff;     // remaining header chars
   logic rd_valid_ff;

   // address byte decode
   logic [3:0] cur_len;
   logic [6:0] c;
   logic [3:0] ssid;
   logic [2:0] nw;
   logic [6:0] w0, w1, w2;
   always_comb begin
      case (cmd.addr_field)
         2'd0:    cur_len = dlen_ff;
         2'd1:    cur_len = slen_ff;
         default: cur_len = cmd.hop_clear ? 4'd0 : hlen_ff;
      endcase
      c = byte_in[7:1];
      ssid = byte_in[4:1];
      nw = 3'd0; w0 = c; w1 = 7'd0; w2 = 7'd0;
      if (cmd.addr_idx < 3'd6) begin
         if (c != 7'h20 && cur_len < 4'(ADDR_TEXT)) nw = 3'd1;
      end else if (ssid != 4'd0 && 5'(cur_len) + 5'd3 <= 5'(ADDR_TEXT)) begin
         w0 = 7'h2d;
         if (ssid >= 4'd10) begin
            nw = 3'd3; w1 = 7'h31; w2 = 7'h30 + 7'(ssid - 4'd10);
         end else begin
            nw = 3'd2; w1 = 7'h30 + 7'(ssid);
         end
      end
   end

   // path write
   logic p_we;
   logic [AW-1:0] p_wa;
   logic [6:0] p_wd;
   always_comb begin
      p_we = 1'b0; p_wa = plen_ff[AW-1:0]; p_wd = 7'h2c;
      if (cmd.copy_start) p_we = 1'b1;
      else if (copy_ff) begin
         p_we = 1'b1; p_wd = hop_ff[ck_ff];
      end
   end

   logic [AW-1:0] p_ra;
   logic [6:0] p_rd;
   ax25_ram #(.WIDTH(7), .DEPTH(PATH_STORE)) u_path (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd)
   );

   // header sequencer: next segment/pointer
   hsel_type sel_in;
   logic [PLW-1:0] hp_in;
   always_comb begin
      sel_in = sel_ff; hp_in = hp_ff + PLW'(1);
      if (cmd.hdr_start) begin
         hp_in = '0;
         sel_in = (slen_ff != 4'd0) ? SEL_SRC : SEL_GT;
      end else begin
         case (sel_ff)
            SEL_SRC: if (hp_in == PLW'(slen_ff)) begin sel_in = SEL_GT; hp_in = '0; end
            SEL_GT: begin
               hp_in = '0;
               sel_in = (dlen_ff != 4'd0) ? SEL_DST
                      : (plen_ff != '0) ? SEL_PATH : SEL_COLON;
            end
            SEL_DST: if (hp_in == PLW'(dlen_ff)) begin
               hp_in = '0;
               sel_in = (plen_ff != '0) ? SEL_PATH : SEL_COLON;
            end
            SEL_PATH: if (hp_in == plen_ff) begin sel_in = SEL_COLON; hp_in = '0; end
            default: hp_in = '0;
         endcase
      end
   end
   // path read address runs one ahead so read data is ready with the pointer
   assign p_ra = (cmd.hdr_start || cmd.hdr_step) ? hp_in[AW-1:0] : hp_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         dlen_ff <= '0; slen_ff <= '0; hlen_ff <= '0; plen_ff <= '0;
         copy_ff <= 1'b0; ck_ff <= '0; sel_ff <= SEL_COLON; hp_ff <= '0;
         hcnt_ff <= '0; rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.hop_clear) hlen_ff <= '0;
         if (cmd.addr_wr) begin
            case (cmd.addr_field)
               2'd0: begin
                  if (nw > 3'd0) dst_ff[dlen_ff] <= w0;
                  if (nw > 3'd1) dst_ff[dlen_ff + 4'd1] <= w1;
                  if (nw > 3'd2) dst_ff[dlen_ff + 4'd2] <= w2;
                  dlen_ff <= dlen_ff + 4'(nw);
               end
               2'd1: begin
                  if (nw > 3'd0) src_ff[slen_ff] <= w0;
                  if (nw > 3'd1) src_ff[slen_ff + 4'd1] <= w1;
                  if (nw > 3'd2) src_ff[slen_ff + 4'd2] <= w2;
                  slen_ff <= slen_ff + 4'(nw);
               end
               default: begin
                  if (nw > 3'd0) hop_ff[cur_len] <= w0;
                  if (nw > 3'd1) hop_ff[cur_len + 4'd1] <= w1;
                  if (nw > 3'd2) hop_ff[cur_len + 4'd2] <= w2;
                  hlen_ff <= cur_len + 4'(nw);
               end
            endcase
         end
         if (p_we) plen_ff <= plen_ff + PLW'(1);
         if (cmd.copy_start) begin
            ck_ff <= '0; copy_ff <= (hlen_ff != 4'd0);
         end else if (copy_ff) begin
            ck_ff <= ck_ff + 4'd1;
            if (ck_ff + 4'd1 == hlen_ff) copy_ff <= 1'b0;
         end
         if (cmd.hdr_start) begin
            hcnt_ff <= 9'(slen_ff) + 9'(dlen_ff) + 9'(plen_ff) + 9'd2;
         end else if (cmd.hdr_step && hcnt_ff != '0) begin
            hcnt_ff <= hcnt_ff - 9'd1;
         end
         if (cmd.hdr_start || cmd.hdr_step) begin
            sel_ff <= sel_in; hp_ff <= hp_in;
         end
         rd_valid_ff <= 1'b1;
      end
   end

   logic [6:0] ch;
   always_comb begin
      case (sel_ff)
         SEL_SRC:  ch = src_ff[hp_ff[3:0]];
         SEL_GT:   ch = 7'h3e;
         SEL_DST:  ch = dst_ff[hp_ff[3:0]];
         SEL_PATH: ch = p_rd;
         default:  ch = 7'h3a;
      endcase
   end

   assign sts.copy_busy = copy_ff;
   assign sts.hop_fits = (PLW+1)'(plen_ff) + (PLW+1)'(hlen_ff) + (PLW+1)'(2)
                         < (PLW+1)'(PATH_STORE);
   assign sts.hdr_char = ch;
   assign sts.hdr_end = (hcnt_ff == '0) || !rd_valid_ff;
   assign sts.hdr_len = hcnt_ff;
endmodule

FILE: hw/rtl/ax25_ctrl.sv
// Controller: frame phase sequencing, handshakes, character limit.
// Depends on ax25_pkg.
module ax25_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_text_capacity,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_frame_byte,
   input  logic              req_frame_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [6:0]        rsp_text_char,
   output logic              rsp_end_of_text,
   output ax25_pkg::cmd_type cmd,
   input  ax25_pkg::sts_type sts
);
   import ax25_pkg::*;

   typedef enum logic [3:0] {
      ST_DEST, ST_SRC, ST_DIGI, ST_COPY, ST_CTRL, ST_PID, ST_INFO, ST_SKIP,
      ST_HDR
   } state_type;

   state_type st_ff, st_in, ret_ff, ret_in;
   logic [2:0]  idx_ff, idx_in;
   logic [15:0] cap_ff;
   logic [15:0] emit_ff, emit_in;
   logic        ext_ff, ext_in;
   logic        last_ff, last_in;     // request that started header run
   logic [6:0]  burst_ff, burst_in;   // chars left in this burst
   logic        bend_ff, bend_in;     // flag end on last burst char
   logic        ov_ff, ov_in;
   logic [6:0]  oc_ff, oc_in;
   logic        oe_ff, oe_in;

   logic [15:0] limit;
   logic        acc, out_free;
   assign limit = (cap_ff == 16'd0) ? 16'd0 : cap_ff - 16'd1;
   assign out_free = !ov_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = ov_ff;
   assign rsp_text_char = oc_ff;
   assign rsp_end_of_text = oe_ff;
   assign req_stall = (st_ff == ST_HDR) || (st_ff == ST_COPY) || !out_free
                      || ((st_ff == ST_INFO || st_ff == ST_CTRL) && !out_free);
   assign acc = req_valid && !req_stall;

   // header remaining, clipped to the limit
   logic [16:0] htot;
   logic [16:0] hrem;
   always_comb begin
      htot = (17'(sts.hdr_len) + 17'(emit_ff) < 17'(limit))
             ? 17'(sts.hdr_len) : 17'(limit) - 17'(emit_ff);
      hrem = htot;
   end

   always_comb begin
      st_in = st_ff; ret_in = ret_ff; idx_in = idx_ff; emit_in = emit_ff;
      ext_in = ext_ff; last_in = last_ff; burst_in = burst_ff; bend_in = bend_ff;
      ov_in = ov_ff && rsp_stall; oc_in = oc_ff; oe_in = oe_ff;
      cmd = '0;
      cmd.addr_idx = idx_ff;
      case (st_ff)
         ST_SRC:  cmd.addr_field = 2'd1;
         ST_DIGI: cmd.addr_field = 2'd2;
         default: cmd.addr_field = 2'd0;
      endcase
      if (acc) begin
         case (st_ff)
            ST_DEST, ST_SRC, ST_DIGI: begin
               cmd.addr_wr = 1'b1;
               if (st_ff == ST_DIGI && idx_ff == 3'd0) cmd.hop_clear = 1'b1;
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd6) begin
                  idx_in = '0;
                  ext_in = req_frame_byte[0];
                  if (st_ff == ST_DEST) st_in = ST_SRC;
                  else if (st_ff == ST_SRC)
                     st_in = req_frame_byte[0] ? ST_CTRL : ST_DIGI;
                  else st_in = ST_COPY;
               end
            end
            ST_CTRL: begin
               if (req_frame_byte != CTRL_UI) st_in = ST_SKIP;
               else if (!req_frame_last) begin
                  cmd.hdr_start = 1'b1;
                  st_in = ST_HDR; ret_in = ST_PID; emit_in = '0;
                  burst_in = 7'd127; bend_in = 1'b0; last_in = 1'b0;
               end else st_in = ST_PID;
            end
            ST_PID: begin
               st_in = ST_INFO;
               if (emit_ff < limit && sts.hdr_len != 9'd0) begin
                  st_in = ST_HDR; ret_in = ST_INFO;
                  burst_in = (hrem > 17'd64) ? 7'd64 : 7'(hrem);
                  bend_in = 1'b1; last_in = req_frame_last;
               end
            end
            ST_INFO: begin
               if (emit_ff < limit) begin
                  ov_in = 1'b1;
                  oc_in = (req_frame_byte >= 8'd32 && req_frame_byte < 8'd127)
                          ? req_frame_byte[6:0] : 7'h2e;
                  emit_in = emit_ff + 16'd1;
                  oe_in = req_frame_last || (emit_ff + 16'd1 >= limit);
               end
            end
            default: ;
         endcase
         if (req_frame_last && st_in != ST_HDR) begin
            cmd.clear = 1'b1; st_in = ST_DEST; idx_in = '0; emit_in = '0;
         end
      end else if (st_ff == ST_COPY) begin
         // wait for the hop to land in the path
         if (!sts.copy_busy) begin
            if (idx_ff == 3'd0 && ret_ff != ST_COPY) begin
               if (sts.hop_fits) cmd.copy_start = 1'b1;
               ret_in = ST_COPY;
            end else begin
               ret_in = ST_DEST;
               st_in = ext_ff ? ST_CTRL : ST_DIGI;
            end
         end
      end else if (st_ff == ST_HDR && out_free) begin
         // first burst: everything but the final header char (at most 64)
         if (ret_ff == ST_PID) begin
            if (hrem <= 17'd1 || emit_ff == 16'd64) st_in = ST_PID;
            else begin
               ov_in = 1'b1; oc_in = sts.hdr_char; oe_in = 1'b0;
               emit_in = emit_ff + 16'd1; cmd.hdr_step = 1'b1;
            end
         end else begin
            if (burst_ff == 7'd0) begin
               st_in = ST_INFO;
               if (last_ff) begin
                  cmd.clear = 1'b1; st_in = ST_DEST; idx_in = '0; emit_in = '0;
               end
            end else begin
               ov_in = 1'b1; oc_in = sts.hdr_char;
               oe_in = (burst_ff == 7'd1) &&
                       (last_ff || emit_ff + 16'd1 >= limit);
               emit_in = emit_ff + 16'd1; cmd.hdr_step = 1'b1;
               burst_in = burst_ff - 7'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_DEST; ret_ff <= ST_DEST; idx_ff <= '0; emit_ff <= '0;
         ext_ff <= 1'b0; last_ff <= 1'b0; burst_ff <= '0; bend_ff <= 1'b0;
         ov_ff <= 1'b0; cap_ff <= CAP_RESET;
      end else begin
         if (csr_valid) cap_ff <= csr_text_capacity;
         st_ff <= (st_ff == ST_SRC && st_in == ST_CTRL) ? ST_CTRL : st_in;
         ret_ff <= (st_in == ST_COPY && st_ff != ST_COPY) ? ST_DEST : ret_in;
         idx_ff <= idx_in; emit_ff <= emit_in; ext_ff <= ext_in;
         last_ff <= last_in; burst_ff <= burst_in; bend_ff <= bend_in;
         ov_ff <= ov_in;
      end
      oc_ff <= oc_in; oe_ff <= oe_in;
   end
endmodule

FILE: dv/testbench.sv
// Testbench for ax25_ui_frame_to_text_top: AX.25 frame bytes in, monitor text out.
// Depends on ax25_pkg and the RTL top level; it predicts the text of random frames itself.
module testbench;
   import ax25_pkg::*;

   localparam int MAX_BURST = 64;
   localparam int LIMIT_CYCLES = 1500000;
   localparam int DRAIN_CYCLES = 200;
   localparam int LONG_HOLD = 400;
   localparam logic [7:0] SPACE_CH = 8'h20;
   localparam logic [7:0] DOT_CH = 8'h2e;

   typedef enum int {
      AWAIT_DST, AWAIT_SRC, AWAIT_HOP, AWAIT_CTRL, AWAIT_PID, IN_INFO, SKIP_REST
   } fphase_type;

   typedef enum int { FR_GOOD, FR_SHORT, FR_NOT_UI, FR_NOISE } fkind_type;

   typedef struct {
      logic [6:0] ch;
      logic       eot;
   } text_item_type;

   typedef struct {
      logic [7:0] b;
      logic       last;
      string      txt;
      logic       eot;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_text_capacity;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_frame_byte;
   logic        req_frame_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [6:0]  rsp_text_char;
   logic        rsp_end_of_text;

   ax25_ui_frame_to_text_top dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_text_capacity(csr_text_capacity),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_frame_byte(req_frame_byte), .req_frame_last(req_frame_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_text_char(rsp_text_char), .rsp_end_of_text(rsp_end_of_text)
   );

   // decoder image
   logic [15:0] capacity;
   fphase_type  phase;
   int          abyte;
   logic [6:0]  dst_t[ADDR_TEXT];
   logic [6:0]  src_t[ADDR_TEXT];
   logic [6:0]  hop_t[ADDR_TEXT];
   logic [6:0]  path_t[PATH_STORE_DEF];
   int          dst_n, src_n, hop_n, path_n, emitted;

   text_item_type pending_text[$];
   text_item_type fresh[$];
   logic [7:0]  frame_q[$];
   int          errors = 0;
   int          cycles = 0;
   bit          quiet;
   int          hold_requests;
   int          hold_served = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int field_len(int fld);
      if (fld == 0) return dst_n;
      if (fld == 1) return src_n;
      return hop_n;
   endfunction

   task automatic put_char(int fld, logic [6:0] c);
      if (fld == 0) begin
         dst_t[dst_n] = c;
         dst_n++;
      end else if (fld == 1) begin
         src_t[src_n] = c;
         src_n++;
      end else begin
         hop_t[hop_n] = c;
         hop_n++;
      end
   endtask

   task automatic decode_addr(int fld, logic [7:0] b, int idx);
      logic [3:0] ssid;
      ssid = b[4:1];
      if (idx < 6) begin
         if (b[7:1] != SPACE_CH[6:0] && field_len(fld) < ADDR_TEXT) put_char(fld, b[7:1]);
      end else if (ssid != 0 && field_len(fld) + 3 <= ADDR_TEXT) begin
         put_char(fld, 7'h2d);
         if (ssid >= 10) begin
            put_char(fld, 7'h31);
            ssid = ssid - 4'd10;
         end
         put_char(fld, 7'h30 + 7'(ssid));
      end
   endtask

   function automatic logic [6:0] header_char(int i);
      if (i < src_n) return src_t[i];
      i -= src_n;
      if (i == 0) return 7'h3e;
      i -= 1;
      if (i < dst_n) return dst_t[i];
      i -= dst_n;
      if (i < path_n) return path_t[i];
      return 7'h3a;
   endfunction

   task automatic start_frame();
      phase = AWAIT_DST;
      abyte = 0;
      dst_n = 0;
      src_n = 0;
      hop_n = 0;
      path_n = 0;
      emitted = 0;
   endtask

   task automatic push_fresh(logic [6:0] c, logic e);
      text_item_type t;
      t.ch = c;
      t.eot = e;
      fresh.push_back(t);
   endtask

   // work out the text one accepted request gives, into fresh
   task automatic predict_text(logic [7:0] b, logic last);
      int limit, hlen, total, k, cnt, pos;
      limit = (capacity == 0) ? 0 : int'(capacity) - 1;
      hlen = src_n + 1 + dst_n + path_n + 1;
      total = (hlen < limit) ? hlen : limit;
      fresh.delete();
      case (phase)
         AWAIT_DST, AWAIT_SRC, AWAIT_HOP: begin
            if (phase == AWAIT_HOP && abyte == 0) hop_n = 0;
            decode_addr(phase == AWAIT_DST ? 0 : (phase == AWAIT_SRC ? 1 : 2), b, abyte);
            abyte++;
            if (abyte >= 7) begin
               abyte = 0;
               if (phase == AWAIT_DST) begin
                  phase = AWAIT_SRC;
               end else begin
                  if (phase == AWAIT_HOP && path_n + hop_n + 2 < PATH_STORE_DEF) begin
                     path_t[path_n] = 7'h2c;
                     path_n++;
                     for (int j = 0; j < hop_n; j++) begin
                        path_t[path_n] = hop_t[j];
                        path_n++;
                     end
                  end
                  phase = b[0] ? AWAIT_CTRL : AWAIT_HOP;
               end
            end
         end
         AWAIT_CTRL: begin
            if (b != CTRL_UI) begin
               phase = SKIP_REST;
            end else begin
               phase = AWAIT_PID;
               if (!last) begin
                  k = (total > 0) ? total - 1 : 0;
                  if (k > MAX_BURST) k = MAX_BURST;
                  for (int j = 0; j < k; j++) push_fresh(header_char(j), 1'b0);
                  emitted = k;
               end
            end
         end
         AWAIT_PID: begin
            pos = emitted;
            cnt = total - pos;
            if (cnt > MAX_BURST) cnt = MAX_BURST;
            if (cnt < 0) cnt = 0;
            for (int j = 0; j < cnt; j++)
               push_fresh(header_char(pos + j), (j == cnt - 1) && (last || pos + cnt >= limit));
            emitted = pos + cnt;
            phase = IN_INFO;
         end
         IN_INFO: begin
            if (emitted < limit) begin
               emitted++;
               push_fresh((b >= 32 && b < 127) ? b[6:0] : DOT_CH[6:0],
                          last || emitted >= limit);
            end
         end
         default: ;
      endcase
      if (last) start_frame();
   endtask

   // one request over the handshake; predicts at acceptance
   task automatic send_byte(logic [7:0] b, logic last, string typed, logic typed_eot,
                            bit use_typed);
      int gap;
      text_item_type t;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frame_byte <= b;
      req_frame_last <= last;
      do @(posedge clock); while (req_stall);
      predict_text(b, last);
      if (use_typed) begin
         for (int j = 0; j < typed.len(); j++) begin
            t.ch = 7'(typed[j]);
            t.eot = typed_eot && (j == typed.len() - 1);
            pending_text.push_back(t);
         end
      end else begin
         foreach (fresh[j]) pending_text.push_back(fresh[j]);
      end
   endtask

   function automatic logic [7:0] call_byte();
      logic [7:0] pick;
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return {SPACE_CH[6:0], 1'b0};
      if (r == 2) return 8'($urandom);
      pick = (r < 7) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(48, 57));
      return {pick[6:0], 1'b0};
   endfunction

   function automatic logic [7:0] ssid_byte(logic [3:0] ssid, logic ext);
      logic [2:0] top;
      top = 3'($urandom);
      return {top, ssid, ext};
   endfunction

   task automatic add_address(logic [3:0] ssid, logic ext, bit full);
      for (int j = 0; j < 6; j++) frame_q.push_back(full ? 8'h82 + 8'(2 * j) : call_byte());
      frame_q.push_back(ssid_byte(ssid, ext));
   endtask

   // build and send one frame; hops < 0 picks a random count
   task automatic send_frame(fkind_type kind, int hops, int info_len, bit long_calls);
      int cut;
      logic [3:0] ssid;
      frame_q.delete();
      if (kind == FR_NOISE) begin
         cut = $urandom_range(1, 30);
         repeat (cut) frame_q.push_back(8'($urandom));
      end else begin
         if (hops < 0) hops = $urandom_range(0, 3);
         add_address(4'($urandom), 1'($urandom), long_calls);
         add_address(4'($urandom), hops == 0, long_calls);
         for (int h = 0; h < hops; h++) begin
            ssid = long_calls ? 4'd15 : 4'($urandom);
            add_address(ssid, h == hops - 1, long_calls);
         end
         frame_q.push_back(kind == FR_NOT_UI ? 8'($urandom_range(4, 255)) : CTRL_UI);
         frame_q.push_back(8'hf0);
         repeat (info_len) frame_q.push_back(8'($urandom));
         if (kind == FR_SHORT) begin
            cut = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > cut) void'(frame_q.pop_back());
         end
      end
      foreach (frame_q[j]) send_byte(frame_q[j], j == frame_q.size() - 1, "", 1'b0, 1'b0);
   endtask

   task automatic drain_and_write(logic [15:0] cap);
      req_valid <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_text_capacity <= cap;
      do @(posedge clock); while (!csr_ready);
      capacity = cap;
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int n_items);
      int sent;
      int r;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 9);
         if (r < 6) send_frame(FR_GOOD, -1, $urandom_range(0, 12), 1'b0);
         else if (r < 8) send_frame(FR_SHORT, -1, 4, 1'b0);
         else if (r == 8) send_frame(FR_NOT_UI, -1, 3, 1'b0);
         else send_frame(FR_NOISE, 0, 0, 1'b0);
         sent += frame_q.size();
      end
   endtask

   // response side: check, then pick the next stall
   int rx_wait;
   int long_left;
   always @(posedge clock) begin
      text_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait = 0;
         long_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_text.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("tb: unexpected char %h eot %b", rsp_text_char, rsp_end_of_text);
            end else begin
               want = pending_text.pop_front();
               if (want.ch !== rsp_text_char || want.eot !== rsp_end_of_text) begin
                  errors++;
                  if (errors <= 10)
                     $display("tb: expected char %h eot %b, got char %h eot %b",
                              want.ch, want.eot, rsp_text_char, rsp_end_of_text);
               end
            end
            rx_wait = quiet ? 0 : $urandom_range(0, 19);
         end
         if (hold_served < hold_requests) begin
            hold_served++;
            long_left = LONG_HOLD;
         end
         if (long_left > 0) begin
            long_left--;
            rsp_stall <= 1'b1;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   dir_row_type ui_rows[$];

   initial begin
      quiet = 1'b0;
      hold_requests = 0;
      capacity = CAP_RESET;
      start_frame();
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_text_capacity = '0;
      req_valid = 1'b0;
      req_frame_byte = '0;
      req_frame_last = 1'b0;
      // "A" to "B", one info byte, then a frame cut after one byte
      ui_rows = '{
         '{8'h84, 1'b0, "", 1'b0}, '{8'h40, 1'b0, "", 1'b0}, '{8'h40, 1'b0, "", 1'b0},
         '{8'h40, 1'b0, "", 1'b0}, '{8'h40, 1'b0, "", 1'b0}, '{8'h40, 1'b0, "", 1'b0},
         '{8'h60, 1'b0, "", 1'b0},
         '{8'h82, 1'b0, "", 1'b0}, '{8'h40, 1'b0, "", 1'b0}, '{8'h40, 1'b0, "", 1'b0},
         '{8'h40, 1'b0, "", 1'b0}, '{8'h40, 1'b0, "", 1'b0}, '{8'h40, 1'b0, "", 1'b0},
         '{8'h61, 1'b0, "", 1'b0},
         '{8'h03, 1'b0, "A>B", 1'b0}, '{8'hf0, 1'b0, ":", 1'b0}, '{8'h78, 1'b1, "x", 1'b1},
         '{8'hff, 1'b1, "", 1'b0}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (ui_rows[i]) send_byte(ui_rows[i].b, ui_rows[i].last, ui_rows[i].txt,
                                     ui_rows[i].eot, 1'b1);
      // path overflow with two-digit SSIDs, non-UI, cut frames, odd info bytes
      send_frame(FR_GOOD, 8, 2, 1'b1);
      send_frame(FR_NOT_UI, 0, 2, 1'b0);
      send_frame(FR_SHORT, 1, 0, 1'b0);
      send_frame(FR_GOOD, 0, 0, 1'b0);

      drain_and_write(16'd1);
      send_frame(FR_GOOD, 1, 3, 1'b0);
      random_phase(5);
      drain_and_write(16'd0);
      send_frame(FR_GOOD, 0, 3, 1'b0);
      random_phase(5);
      drain_and_write(16'd5);
      random_phase(10);
      drain_and_write(16'hffff);
      quiet = 1'b1;
      random_phase(10);
      quiet = 1'b0;
      hold_requests++;
      send_frame(FR_GOOD, 2, 12, 1'b1);
      random_phase(10);
      drain_and_write(16'd40);
      random_phase(5);
      drain_and_write(16'($urandom_range(2, 120)));
      random_phase(10);
      drain_and_write(CAP_RESET);
      random_phase(5);

      req_valid <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_text.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
